// ----- sv/mfq_pkg.sv -----
// ----------------------------------------------------------------------------
// mfq_pkg
// Shared constants and types for the three-level feedback queue scheduler.
// ----------------------------------------------------------------------------
package mfq_pkg;

  localparam int DEF_MAX_PROCS  = 8;
  localparam int DEF_TIME_SLOTS = 20;

  // Queue level codes
  localparam logic [1:0] LV_TOP = 2'd0;
  localparam logic [1:0] LV_MID = 2'd1;
  localparam logic [1:0] LV_BOT = 2'd2;

  localparam logic [3:0] QB_RESET = 4'd2;

  // Control request from the sequencer to the level queues
  typedef struct packed {
    logic       clear;
    logic       push;
    logic [1:0] push_lv;
    logic       pop;
    logic [1:0] pop_lv;
  } q_ctrl_t;

endpackage

// ----- sv/mfq_level_queues.sv -----
// ----------------------------------------------------------------------------
// mfq_level_queues
// Three circular FIFOs of process ids, one per level, with head and count.
// ----------------------------------------------------------------------------
module mfq_level_queues
  import mfq_pkg::*;
#(
  parameter int MAX_PROCS = DEF_MAX_PROCS,
  parameter int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1,
  parameter int CW = $clog2(MAX_PROCS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  q_ctrl_t       ctrl,
  input  logic [IW-1:0] push_id,
  output logic [IW-1:0] head_id,
  output logic [CW-1:0] cnt0,
  output logic [CW-1:0] cnt1,
  output logic [CW-1:0] cnt2
);

  localparam logic [CW:0] MAXV = (CW + 1)'(MAX_PROCS);

  logic [IW-1:0] qmem [3][MAX_PROCS];
  logic [IW-1:0] head [3];
  logic [CW-1:0] cnt  [3];
  logic [CW:0]   tail_sum;
  logic [CW:0]   tail_w;

  assign cnt0    = cnt[0];
  assign cnt1    = cnt[1];
  assign cnt2    = cnt[2];
  assign head_id = qmem[ctrl.pop_lv][head[ctrl.pop_lv]];

  // Tail slot of the level being pushed, wrapped at the depth
  always_comb begin
    tail_sum = (CW + 1)'(head[ctrl.push_lv]) + (CW + 1)'(cnt[ctrl.push_lv]);
    tail_w   = (tail_sum >= MAXV) ? tail_sum - MAXV : tail_sum;
  end

  // Store the pushed id
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      qmem[ctrl.push_lv][tail_w[IW-1:0]] <= push_id;
    end
  end

  // Advance heads and counts
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int i = 0; i < 3; i++) begin
        head[i] <= '0;
        cnt[i]  <= '0;
      end
    end else begin
      if (ctrl.push) begin
        cnt[ctrl.push_lv] <= cnt[ctrl.push_lv] + 1'b1;
      end
      if (ctrl.pop) begin
        cnt[ctrl.pop_lv] <= cnt[ctrl.pop_lv] - 1'b1;
        if ((CW + 1)'(head[ctrl.pop_lv]) == MAXV - 1'b1) begin
          head[ctrl.pop_lv] <= '0;
        end else begin
          head[ctrl.pop_lv] <= head[ctrl.pop_lv] + 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/multilevel_feedback_queue_scheduler.sv -----
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Loads process descriptors and emits a three-level feedback schedule.
// ----------------------------------------------------------------------------
// The request marked last_process starts a run that emits TIME_SLOTS
// results, one per slot in order, each on the result ports for one cycle
// under result_valid; the receiver cannot stall. Busy stays high for the
// whole run. Every slot, idle or busy, costs an admission scan over the
// loaded processes, then the emit and the dispatch or read back of the
// running process; each quantum adds steps to dispatch, pop the queue,
// read the table and requeue. The run time is set by the sequential scan
// over the process tables through a single table read port.
module multilevel_feedback_queue_scheduler
  import mfq_pkg::*;
#(
  parameter int MAX_PROCS  = DEF_MAX_PROCS,
  parameter int TIME_SLOTS = DEF_TIME_SLOTS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [5:0] arrival_time,
  input  logic [5:0] service_time,
  input  logic       last_process,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  output logic       result_valid,
  output logic [5:0] slot_index,
  output logic       busy_res,
  output logic [2:0] process_id,
  output logic       last_slot
);

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_PROCS);
  localparam logic [6:0] TS   = 7'(TIME_SLOTS);
  localparam logic [6:0] TSM1 = 7'(TIME_SLOTS - 1);

  // Sequencer states
  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_TOP   = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_POP   = 3'd4;
  localparam logic [2:0] ST_REM   = 3'd5;
  localparam logic [2:0] ST_RUN   = 3'd6;

  logic [2:0]    state;
  logic [3:0]    quantum_base;
  logic [5:0]    arr_tab [MAX_PROCS];
  logic [5:0]    rem_tab [MAX_PROCS];
  logic [MAX_PROCS-1:0] admitted;
  logic [CW-1:0] process_count;
  logic [CW-1:0] scan_j;
  logic          ret_run;
  logic [6:0]    slot;
  logic [IW-1:0] idx;
  // Running process id, kept across the admission scan
  logic [IW-1:0] run_idx;
  logic [1:0]    run_lv;
  logic [7:0]    quantum;
  logic [7:0]    kcnt;
  logic [5:0]    cur_rem;
  logic [3:0]    qb;

  q_ctrl_t       qctrl;
  logic [IW-1:0] push_id;
  logic [IW-1:0] head_id;
  logic [CW-1:0] cnt0, cnt1, cnt2;
  logic          all_empty;
  logic          ready_hit;
  logic [1:0]    sel_lv;

  assign busy      = (state != ST_LOAD);
  assign qb        = (quantum_base == 4'd0) ? 4'd1 : quantum_base;
  assign all_empty = (cnt0 == '0) && (cnt1 == '0) && (cnt2 == '0);
  assign sel_lv    = (cnt0 != '0) ? LV_TOP : ((cnt1 != '0) ? LV_MID : LV_BOT);
  assign ready_hit = (rem_tab[idx] != 6'd0) && ({1'b0, arr_tab[idx]} <= slot)
                     && !admitted[idx];

  // Queue requests from the sequencer
  always_comb begin
    qctrl         = '0;
    push_id       = idx;
    qctrl.pop_lv  = sel_lv;
    qctrl.push_lv = LV_TOP;
    case (state)
      ST_SCAN: begin
        qctrl.push = (scan_j < process_count) && ready_hit;
      end
      ST_POP: begin
        qctrl.pop = 1'b1;
      end
      ST_RUN: begin
        if (!((kcnt < quantum) && (cur_rem != 6'd0) && (slot < TS))) begin
          qctrl.push    = (cur_rem != 6'd0);
          qctrl.push_lv = (run_lv == LV_TOP) ? (all_empty ? LV_TOP : LV_MID) : LV_BOT;
        end
      end
      ST_TOP: begin
        qctrl.clear = (slot >= TS);
      end
      default: begin
      end
    endcase
  end

  mfq_level_queues #(
    .MAX_PROCS(MAX_PROCS),
    .IW(IW),
    .CW(CW)
  ) u_queues (
    .clk(clk),
    .rst(rst),
    .ctrl(qctrl),
    .push_id(push_id),
    .head_id(head_id),
    .cnt0(cnt0),
    .cnt1(cnt1),
    .cnt2(cnt2)
  );

  // Hold the quantum register
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_base <= QB_RESET;
    end else if (cfg_wr_en) begin
      quantum_base <= cfg_wr_data;
    end
  end

  // Process tables
  always_ff @(posedge clk) begin
    if (state == ST_LOAD && start && process_count < MAXC) begin
      arr_tab[process_count[IW-1:0]] <= arrival_time;
      rem_tab[process_count[IW-1:0]] <= service_time;
    end else if (state == ST_RUN &&
                 !((kcnt < quantum) && (cur_rem != 6'd0) && (slot < TS))) begin
      rem_tab[idx] <= cur_rem;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      admitted      <= '0;
      process_count <= '0;
      result_valid  <= 1'b0;
      slot          <= '0;
      scan_j        <= '0;
      ret_run       <= 1'b0;
      idx           <= '0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_LOAD: begin
          if (start) begin
            if (process_count < MAXC) begin
              admitted[process_count[IW-1:0]] <= 1'b0;
              process_count <= process_count + 1'b1;
            end
            if (last_process) begin
              slot  <= '0;
              state <= ST_TOP;
            end
          end
        end
        ST_TOP: begin
          if (slot >= TS) begin
            admitted      <= '0;
            process_count <= '0;
            state         <= ST_LOAD;
          end else if (all_empty) begin
            scan_j  <= '0;
            idx     <= '0;
            ret_run <= 1'b0;
            state   <= ST_SCAN;
          end else begin
            state <= ST_POP;
          end
        end
        ST_SCAN: begin
          // Admit one ready process per cycle, in index order
          if (scan_j < process_count) begin
            if (ready_hit) begin
              admitted[idx] <= 1'b1;
            end
            scan_j <= scan_j + 1'b1;
            idx    <= IW'(scan_j + 1'b1);
          end else begin
            if (ret_run) begin
              idx <= run_idx;
            end
            state <= ret_run ? ST_REM : ST_EMPTY;
          end
        end
        ST_EMPTY: begin
          // Idle slot when nothing was admitted
          if (cnt0 == '0) begin
            result_valid <= 1'b1;
            slot_index   <= slot[5:0];
            busy_res     <= 1'b0;
            process_id   <= 3'd0;
            last_slot    <= (slot == TSM1);
            slot         <= slot + 1'b1;
          end
          state <= ST_TOP;
        end
        ST_POP: begin
          run_lv <= sel_lv;
          idx    <= head_id;
          kcnt   <= '0;
          case (sel_lv)
            LV_TOP:  quantum <= 8'd1;
            LV_MID:  quantum <= {4'd0, qb};
            default: quantum <= {4'd0, qb} * {4'd0, qb};
          endcase
          state <= ST_REM;
        end
        ST_REM: begin
          if (!ret_run) begin
            cur_rem <= rem_tab[idx];
          end
          ret_run <= 1'b0;
          state   <= ST_RUN;
        end
        ST_RUN: begin
          if ((kcnt < quantum) && (cur_rem != 6'd0) && (slot < TS)) begin
            result_valid <= 1'b1;
            slot_index   <= slot[5:0];
            busy_res     <= 1'b1;
            process_id   <= 3'(idx);
            last_slot    <= (slot == TSM1);
            slot         <= slot + 1'b1;
            cur_rem      <= cur_rem - 1'b1;
            kcnt         <= kcnt + 1'b1;
            run_idx      <= idx;
            scan_j       <= '0;
            idx          <= '0;
            ret_run      <= 1'b1;
            state        <= ST_SCAN;
          end else begin
            state <= ST_TOP;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule
